// ----- rtl/core/fsmc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fsmc_pkg;

   localparam int FifoDepth = 8;
   localparam int PtrWidth  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
   localparam int FillWidth = $clog2(FifoDepth + 1);
   localparam int FlagLevel = 4;

   localparam logic [1:0] OpRead  = 2'd0;
   localparam logic [1:0] OpWrite = 2'd1;
   localparam logic [1:0] OpReply = 2'd2;

   localparam logic [2:0] RegRxData  = 3'd0;
   localparam logic [2:0] RegTxData  = 3'd1;
   localparam logic [2:0] RegControl = 3'd2;
   localparam logic [2:0] RegStatus  = 3'd3;
   localparam logic [2:0] RegTest    = 3'd4;
   localparam logic [2:0] RegPeriod  = 3'd5;

   localparam int CtlXchBit    = 8;
   localparam int CtlEnBit     = 9;
   localparam int CtlMasterBit = 10;

   localparam logic [3:0] WidthByte = 4'd7;
   localparam logic [3:0] WidthWord = 4'd15;

   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } fifo_ctl_type;

   typedef enum logic [2:0] {
      SEQ_IDLE = 3'b001,
      SEQ_WALK = 3'b010,
      SEQ_DONE = 3'b100
   } seq_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_BYTE = 4'b0010,
      PH_HIGH = 4'b0100,
      PH_LOW  = 4'b1000
   } phase_type;

endpackage

`default_nettype wire

// ----- rtl/core/fsmc_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fsmc_fifo (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire fsmc_pkg::fifo_ctl_type         ctl,
   input  wire logic [15:0]                    push_data,
   output logic [fsmc_pkg::FillWidth-1:0]      fill,
   output logic [15:0]                         head_data
);

   localparam int SumWidth = fsmc_pkg::PtrWidth + 1;

   logic [15:0]                        store_ff [fsmc_pkg::FifoDepth];
   logic [fsmc_pkg::PtrWidth-1:0]      head_ff, head_in;
   logic [fsmc_pkg::FillWidth-1:0]     fill_ff, fill_in;
   logic [SumWidth-1:0]                tail_sum;
   logic [fsmc_pkg::PtrWidth-1:0]      tail;
   logic                               full;
   logic                               do_push;
   logic                               do_pop;

   assign full     = fill_ff == fsmc_pkg::FillWidth'(fsmc_pkg::FifoDepth);
   assign do_push  = ctl.push && !full;
   assign do_pop   = ctl.pop && (fill_ff != '0);
   assign tail_sum = SumWidth'(head_ff) + SumWidth'(fill_ff);

   always_comb begin
      if (tail_sum >= SumWidth'(fsmc_pkg::FifoDepth)) begin
         tail = fsmc_pkg::PtrWidth'(tail_sum - SumWidth'(fsmc_pkg::FifoDepth));
      end else begin
         tail = fsmc_pkg::PtrWidth'(tail_sum);
      end
   end

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (ctl.flush) begin
         head_in = '0;
         fill_in = '0;
      end else begin
         if (do_pop) begin
            if (head_ff == fsmc_pkg::PtrWidth'(fsmc_pkg::FifoDepth - 1)) begin
               head_in = '0;
            end else begin
               head_in = head_ff + fsmc_pkg::PtrWidth'(1);
            end
         end
         if (do_push && !do_pop) begin
            fill_in = fill_ff + fsmc_pkg::FillWidth'(1);
         end else if (do_pop && !do_push) begin
            fill_in = fill_ff - fsmc_pkg::FillWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push && !ctl.flush) begin
         store_ff[tail] <= push_data;
      end
   end

   assign fill      = fill_ff;
   assign head_data = store_ff[head_ff];

endmodule

`default_nettype wire

// ----- rtl/core/fifo_spi_master_controller_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// SPI master register block with TX and RX FIFOs.
// req_ carries one word: a bus read, a bus write, or a slave reply byte
// (operation selects). rsp_ returns one word per request: read data, irq
// level, the byte to shift to the slave (send_valid), exchange busy and
// access refused.
// A bus access or a reply that does not walk the TX FIFO gives its
// response the cycle after acceptance. A rising exchange bit, or a reply that
// ends a word, starts a walk of the TX FIFO by a small sequencer, one TX word
// per cycle, until a word needs the slave or the FIFO is empty.
// One request is in flight at a time; req_ready is low from acceptance until
// the response is taken, so a stalled rsp_ready holds the block and the
// response steady.
// Reset: registers zero, FIFOs empty, no exchange pending, status reads TX
// empty. No clearing pass is needed.

module fifo_spi_master_controller_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic [2:0]  req_reg_index,
   input  wire logic [15:0] req_write_data,
   input  wire logic [7:0]  req_reply_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_read_data,
   output logic             rsp_irq,
   output logic             rsp_send_valid,
   output logic [7:0]       rsp_send_byte,
   output logic             rsp_exchange_busy,
   output logic             rsp_access_refused
);

   fsmc_pkg::seq_type                  seq_ff, seq_in;
   fsmc_pkg::phase_type                phase_ff, phase_in;
   logic [15:0]                        control_ff, control_in;
   logic                               done_ff, done_in;
   logic [7:0]                         mask_ff, mask_in;
   logic [15:0]                        period_ff, period_in;
   logic [15:0]                        wif_ff, wif_in;
   logic [7:0]                         reply_high_ff, reply_high_in;
   logic [15:0]                        rd_ff, rd_in;
   logic                               sv_ff, sv_in;
   logic [7:0]                         send_ff, send_in;
   logic                               refused_ff, refused_in;

   fsmc_pkg::fifo_ctl_type             tx_ctl;
   fsmc_pkg::fifo_ctl_type             rx_ctl;
   logic [fsmc_pkg::FillWidth-1:0]     tx_fill;
   logic [fsmc_pkg::FillWidth-1:0]     rx_fill;
   logic [15:0]                        tx_head_data;
   logic [15:0]                        rx_head_data;
   logic [15:0]                        rx_push_data;
   logic                               rx_push_req;
   logic [5:0]                         flags;
   logic [15:0]                        status_word;
   logic [15:0]                        test_word;
   logic [15:0]                        ones_word;
   logic                               accept;

   fsmc_fifo u_tx_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (tx_ctl),
      .push_data (req_write_data),
      .fill      (tx_fill),
      .head_data (tx_head_data)
   );

   fsmc_fifo u_rx_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (rx_ctl),
      .push_data (rx_push_data),
      .fill      (rx_fill),
      .head_data (rx_head_data)
   );

   assign flags[5] = rx_fill == fsmc_pkg::FillWidth'(fsmc_pkg::FifoDepth);
   assign flags[4] = 16'(rx_fill) >= 16'(fsmc_pkg::FlagLevel);
   assign flags[3] = rx_fill != '0;
   assign flags[2] = tx_fill == fsmc_pkg::FillWidth'(fsmc_pkg::FifoDepth);
   assign flags[1] = 16'(tx_fill) >= 16'(fsmc_pkg::FlagLevel);
   assign flags[0] = tx_fill == '0;

   assign status_word = {mask_ff, 1'b0, done_ff, flags};
   assign test_word   = 16'(tx_fill) | (16'(rx_fill) << 4);
   assign ones_word   = 16'hffff >> (4'd15 - control_ff[3:0]);
   assign accept      = req_valid && req_ready;

   always_comb begin
      seq_in        = seq_ff;
      phase_in      = phase_ff;
      control_in    = control_ff;
      done_in       = done_ff;
      mask_in       = mask_ff;
      period_in     = period_ff;
      wif_in        = wif_ff;
      reply_high_in = reply_high_ff;
      rd_in         = rd_ff;
      sv_in         = sv_ff;
      send_in       = send_ff;
      refused_in    = refused_ff;
      tx_ctl        = '0;
      rx_ctl        = '0;
      rx_push_req   = 1'b0;
      rx_push_data  = '0;

      case (seq_ff)
         fsmc_pkg::SEQ_IDLE: begin
            if (accept) begin
               rd_in      = '0;
               sv_in      = 1'b0;
               send_in    = '0;
               refused_in = 1'b0;
               seq_in     = fsmc_pkg::SEQ_DONE;
               if (req_operation == fsmc_pkg::OpReply) begin
                  case (phase_ff)
                     fsmc_pkg::PH_BYTE: begin
                        rx_push_req  = 1'b1;
                        rx_push_data = {8'h00, req_reply_byte};
                        seq_in       = fsmc_pkg::SEQ_WALK;
                     end
                     fsmc_pkg::PH_HIGH: begin
                        reply_high_in = req_reply_byte;
                        phase_in      = fsmc_pkg::PH_LOW;
                        send_in       = wif_ff[7:0];
                        sv_in         = 1'b1;
                     end
                     fsmc_pkg::PH_LOW: begin
                        rx_push_req  = 1'b1;
                        rx_push_data = {reply_high_ff, req_reply_byte};
                        seq_in       = fsmc_pkg::SEQ_WALK;
                     end
                     default: begin
                     end
                  endcase
               end else if ((req_operation == fsmc_pkg::OpRead ||
                             req_operation == fsmc_pkg::OpWrite) &&
                            phase_ff != fsmc_pkg::PH_IDLE) begin
                  refused_in = 1'b1;
               end else if (req_operation == fsmc_pkg::OpRead) begin
                  case (req_reg_index)
                     fsmc_pkg::RegRxData: begin
                        if (rx_fill != '0) begin
                           rd_in      = rx_head_data;
                           rx_ctl.pop = 1'b1;
                        end
                     end
                     fsmc_pkg::RegControl: rd_in = control_ff;
                     fsmc_pkg::RegStatus: begin
                        rd_in   = status_word;
                        done_in = 1'b0;
                     end
                     fsmc_pkg::RegTest:   rd_in = test_word;
                     fsmc_pkg::RegPeriod: rd_in = period_ff;
                     default: begin
                     end
                  endcase
               end else if (req_operation == fsmc_pkg::OpWrite) begin
                  case (req_reg_index)
                     fsmc_pkg::RegTxData: begin
                        if (control_ff[fsmc_pkg::CtlEnBit] && !flags[2]) begin
                           tx_ctl.push = 1'b1;
                        end
                     end
                     fsmc_pkg::RegControl: begin
                        control_in = req_write_data;
                        if (!req_write_data[fsmc_pkg::CtlEnBit]) begin
                           tx_ctl.flush = 1'b1;
                           rx_ctl.flush = 1'b1;
                        end
                        if (!(req_write_data[fsmc_pkg::CtlEnBit] &&
                              req_write_data[fsmc_pkg::CtlMasterBit])) begin
                           control_in[fsmc_pkg::CtlXchBit] = 1'b0;
                        end else if (req_write_data[fsmc_pkg::CtlXchBit] &&
                                     !control_ff[fsmc_pkg::CtlXchBit]) begin
                           seq_in = fsmc_pkg::SEQ_WALK;
                        end
                     end
                     fsmc_pkg::RegStatus: mask_in   = req_write_data[15:8];
                     fsmc_pkg::RegPeriod: period_in = req_write_data;
                     default: begin
                     end
                  endcase
               end
            end
         end
         fsmc_pkg::SEQ_WALK: begin
            if (tx_fill != '0) begin
               tx_ctl.pop = 1'b1;
               if (control_ff[3:0] == fsmc_pkg::WidthByte) begin
                  wif_in   = tx_head_data;
                  phase_in = fsmc_pkg::PH_BYTE;
                  send_in  = tx_head_data[7:0];
                  sv_in    = 1'b1;
                  seq_in   = fsmc_pkg::SEQ_DONE;
               end else if (control_ff[3:0] == fsmc_pkg::WidthWord) begin
                  wif_in   = tx_head_data;
                  phase_in = fsmc_pkg::PH_HIGH;
                  send_in  = tx_head_data[15:8];
                  sv_in    = 1'b1;
                  seq_in   = fsmc_pkg::SEQ_DONE;
               end else begin
                  rx_push_req  = 1'b1;
                  rx_push_data = ones_word;
               end
            end else begin
               phase_in                        = fsmc_pkg::PH_IDLE;
               control_in[fsmc_pkg::CtlXchBit] = 1'b0;
               seq_in                          = fsmc_pkg::SEQ_DONE;
            end
         end
         fsmc_pkg::SEQ_DONE: begin
            if (rsp_ready) begin
               seq_in = fsmc_pkg::SEQ_IDLE;
            end
         end
         default: begin
            seq_in = fsmc_pkg::SEQ_IDLE;
         end
      endcase

      // transfer done marks a push into an empty RX FIFO, dropped or not
      if (rx_push_req) begin
         rx_ctl.push = !flags[5];
         if (rx_fill == '0) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= fsmc_pkg::SEQ_IDLE;
         phase_ff      <= fsmc_pkg::PH_IDLE;
         control_ff    <= '0;
         done_ff       <= 1'b0;
         mask_ff       <= '0;
         period_ff     <= '0;
         wif_ff        <= '0;
         reply_high_ff <= '0;
      end else begin
         seq_ff        <= seq_in;
         phase_ff      <= phase_in;
         control_ff    <= control_in;
         done_ff       <= done_in;
         mask_ff       <= mask_in;
         period_ff     <= period_in;
         wif_ff        <= wif_in;
         reply_high_ff <= reply_high_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff      <= rd_in;
      sv_ff      <= sv_in;
      send_ff    <= send_in;
      refused_ff <= refused_in;
   end

   assign req_ready          = seq_ff == fsmc_pkg::SEQ_IDLE;
   assign rsp_valid          = seq_ff == fsmc_pkg::SEQ_DONE;
   assign rsp_read_data      = rd_ff;
   assign rsp_irq            = |(flags & mask_ff[5:0]);
   assign rsp_send_valid     = sv_ff;
   assign rsp_send_byte      = send_ff;
   assign rsp_exchange_busy  = phase_ff != fsmc_pkg::PH_IDLE;
   assign rsp_access_refused = refused_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response is pending");

   a_send_means_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_send_valid) |-> rsp_exchange_busy)
      else $error("byte sent with no exchange pending");

   a_refused_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_access_refused) |-> (rsp_exchange_busy && rsp_read_data == 16'h0000))
      else $error("refused access outside an exchange or with data");

   a_xch_cleared: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == fsmc_pkg::SEQ_IDLE && phase_ff == fsmc_pkg::PH_IDLE)
         |-> !control_ff[fsmc_pkg::CtlXchBit])
      else $error("exchange bit left set with no exchange pending");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import fsmc_pkg::*;

   localparam logic [1:0] OpUnused    = 2'd3;
   localparam logic [2:0] RegUnusedLo = 3'd6;
   localparam logic [2:0] RegUnusedHi = 3'd7;
   localparam int StDoneBit     = 6;
   localparam int RandomWords   = 1300;
   localparam int HoldOffCycles = 400;
   localparam int WatchdogLimit = 3000;
   localparam int MaxReports    = 100;

   typedef struct packed {
      logic [1:0]  op;
      logic [2:0]  idx;
      logic [15:0] wdata;
      logic [7:0]  reply;
      logic        drain_first;
   } spi_access_t;

   typedef struct packed {
      logic [15:0] read_data;
      logic        irq;
      logic        send_valid;
      logic [7:0]  send_byte;
      logic        busy;
      logic        refused;
   } spi_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = '0;
   logic [2:0]  req_reg_index = '0;
   logic [15:0] req_write_data = '0;
   logic [7:0]  req_reply_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_read_data;
   logic        rsp_irq;
   logic        rsp_send_valid;
   logic [7:0]  rsp_send_byte;
   logic        rsp_exchange_busy;
   logic        rsp_access_refused;

   spi_access_t access_queue[$];
   spi_result_t expected_results[$];
   spi_access_t offered;
   int words_accepted = 0;
   int results_seen = 0;
   int mismatch_count = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   bit held_once = 1'b0;
   bit drain_next = 1'b0;

   // SPI controller state as the software sees it
   logic [15:0] ctl_q, status_q, period_q;
   logic [15:0] txq[FifoDepth];
   logic [15:0] rxq[FifoDepth];
   int tx_hd, tx_n, rx_hd, rx_n;
   phase_type   xfer_phase;
   logic [15:0] inflight;
   logic [7:0]  hi_reply;

   fifo_spi_master_controller_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_reg_index(req_reg_index),
      .req_write_data(req_write_data),
      .req_reply_byte(req_reply_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data),
      .rsp_irq(rsp_irq),
      .rsp_send_valid(rsp_send_valid),
      .rsp_send_byte(rsp_send_byte),
      .rsp_exchange_busy(rsp_exchange_busy),
      .rsp_access_refused(rsp_access_refused)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void flags_update();
      logic [5:0] f;
      f[0] = tx_n == 0;
      f[1] = tx_n >= FlagLevel;
      f[2] = tx_n == FifoDepth;
      f[3] = rx_n > 0;
      f[4] = rx_n >= FlagLevel;
      f[5] = rx_n == FifoDepth;
      status_q = {status_q[15:8], 1'b0, status_q[StDoneBit], f};
   endfunction

   function automatic void controller_reset();
      ctl_q = '0;
      status_q = '0;
      period_q = '0;
      foreach (txq[i]) txq[i] = '0;
      foreach (rxq[i]) rxq[i] = '0;
      tx_hd = 0;
      tx_n = 0;
      rx_hd = 0;
      rx_n = 0;
      xfer_phase = PH_IDLE;
      inflight = '0;
      hi_reply = '0;
      flags_update();
   endfunction

   function automatic void rx_push(logic [15:0] v);
      if (rx_n == 0) status_q[StDoneBit] = 1'b1;
      if (rx_n < FifoDepth) begin
         rxq[(rx_hd + rx_n) % FifoDepth] = v;
         rx_n++;
         flags_update();
      end
   endfunction

   // drain TX until a word needs the slave
   function automatic logic tx_walk(output logic [7:0] out_byte);
      logic [15:0] w;
      logic [3:0] width;
      out_byte = '0;
      while (tx_n > 0) begin
         w = txq[tx_hd];
         tx_hd = (tx_hd + 1) % FifoDepth;
         tx_n--;
         flags_update();
         width = ctl_q[3:0];
         if (width == WidthByte) begin
            inflight = w;
            xfer_phase = PH_BYTE;
            out_byte = w[7:0];
            return 1'b1;
         end
         if (width == WidthWord) begin
            inflight = w;
            xfer_phase = PH_HIGH;
            out_byte = w[15:8];
            return 1'b1;
         end
         rx_push(16'hffff >> (WidthWord - width));
      end
      xfer_phase = PH_IDLE;
      ctl_q[CtlXchBit] = 1'b0;
      flags_update();
      return 1'b0;
   endfunction

   function automatic spi_result_t spi_predict(spi_access_t r);
      spi_result_t e;
      logic [15:0] old;
      logic [7:0] sb;
      e = '0;
      sb = '0;
      if (r.op == OpReply) begin
         case (xfer_phase)
            PH_BYTE: begin
               rx_push({8'h00, r.reply});
               e.send_valid = tx_walk(sb);
            end
            PH_HIGH: begin
               hi_reply = r.reply;
               xfer_phase = PH_LOW;
               sb = inflight[7:0];
               e.send_valid = 1'b1;
            end
            PH_LOW: begin
               rx_push({hi_reply, r.reply});
               e.send_valid = tx_walk(sb);
            end
            default: ;
         endcase
      end else if ((r.op == OpRead || r.op == OpWrite) && xfer_phase != PH_IDLE) begin
         e.refused = 1'b1;
      end else if (r.op == OpRead) begin
         case (r.idx)
            RegRxData: begin
               if (rx_n > 0) begin
                  e.read_data = rxq[rx_hd];
                  rx_hd = (rx_hd + 1) % FifoDepth;
                  rx_n--;
               end
               flags_update();
            end
            RegControl: e.read_data = ctl_q;
            RegStatus: begin
               e.read_data = status_q;
               status_q[StDoneBit] = 1'b0;
            end
            RegTest: e.read_data = 16'(tx_n | (rx_n << 4));
            RegPeriod: e.read_data = period_q;
            default: ;
         endcase
      end else if (r.op == OpWrite) begin
         case (r.idx)
            RegTxData: begin
               if (ctl_q[CtlEnBit] && tx_n < FifoDepth) begin
                  txq[(tx_hd + tx_n) % FifoDepth] = r.wdata;
                  tx_n++;
                  flags_update();
               end
            end
            RegControl: begin
               old = ctl_q;
               ctl_q = r.wdata;
               if (!r.wdata[CtlEnBit]) begin
                  tx_hd = 0;
                  tx_n = 0;
                  rx_hd = 0;
                  rx_n = 0;
                  flags_update();
               end
               if (!(r.wdata[CtlEnBit] && r.wdata[CtlMasterBit]))
                  ctl_q[CtlXchBit] = 1'b0;
               else if (r.wdata[CtlXchBit] && !old[CtlXchBit])
                  e.send_valid = tx_walk(sb);
            end
            RegStatus: begin
               status_q = {r.wdata[15:8], status_q[7:0]};
               flags_update();
            end
            RegPeriod: period_q = r.wdata;
            default: ;
         endcase
      end
      e.irq = |(status_q[5:0] & status_q[13:8]);
      e.send_byte = e.send_valid ? sb : 8'h00;
      e.busy = xfer_phase != PH_IDLE;
      return e;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (mismatch_count < MaxReports)
         $display("mismatch on word %0d: %s got %h expected %h", results_seen, what, got, want);
      mismatch_count++;
   endtask

   task automatic queue_word(logic [1:0] op, logic [2:0] idx, logic [15:0] wdata,
                             logic [7:0] reply);
      spi_access_t a;
      a.op = op;
      a.idx = idx;
      a.wdata = wdata;
      a.reply = reply;
      a.drain_first = drain_next;
      drain_next = 1'b0;
      access_queue.push_back(a);
   endtask

   task automatic bus_write(logic [2:0] idx, logic [15:0] wdata);
      queue_word(OpWrite, idx, wdata, 8'($urandom));
   endtask

   task automatic bus_read(logic [2:0] idx);
      queue_word(OpRead, idx, 16'($urandom), 8'($urandom));
   endtask

   task automatic slave_reply(logic [7:0] reply);
      queue_word(OpReply, 3'($urandom), 16'($urandom), reply);
   endtask

   function automatic logic [15:0] pick_data();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_reply();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] control_value(logic [15:0] extra, logic [3:0] width,
                                                 bit en, bit master, bit xch);
      logic [15:0] v;
      v = extra;
      v[3:0] = width;
      v[CtlEnBit] = en;
      v[CtlMasterBit] = master;
      v[CtlXchBit] = xch;
      return v;
   endfunction

   task automatic exchange_sequence();
      logic [3:0] width;
      logic [15:0] extra;
      bit en, master;
      int n, need;
      case ($urandom_range(9))
         0, 1, 2, 3: width = WidthByte;
         4, 5, 6, 7: width = WidthWord;
         default: width = 4'($urandom_range(15));
      endcase
      extra = 16'($urandom);
      en = $urandom_range(19) != 0;
      master = $urandom_range(19) != 0;
      bus_write(RegControl, control_value(extra, width, en, master, 1'b0));
      if ($urandom_range(3) == 0) bus_write(RegStatus, pick_data());
      n = $urandom_range(9);
      repeat (n) bus_write(RegTxData, pick_data());
      bus_write(RegControl, control_value(extra, width, en, master, 1'b1));
      if (n > FifoDepth) n = FifoDepth;
      need = (width == WidthByte) ? n : (width == WidthWord) ? 2 * n : 0;
      need += $urandom_range(1);
      repeat (need) begin
         if ($urandom_range(9) == 0) begin
            if ($urandom_range(1)) bus_read(3'($urandom_range(7)));
            else bus_write(RegPeriod, pick_data());
         end
         slave_reply(pick_reply());
      end
      repeat ($urandom_range(9)) bus_read(RegRxData);
      if ($urandom_range(1)) bus_read(RegStatus);
      if ($urandom_range(3) == 0) bus_read(RegTest);
   endtask

   initial begin : stimulus
      int base;
      bit paused;
      paused = 1'b0;
      controller_reset();

      bus_read(RegStatus);
      bus_read(RegControl);
      bus_read(RegTest);
      bus_read(RegRxData);
      bus_write(RegPeriod, 16'hffff);
      bus_read(RegPeriod);
      bus_write(RegStatus, 16'hffff);
      bus_write(RegControl, control_value(16'h0000, WidthByte, 1'b1, 1'b1, 1'b0));
      bus_write(RegTxData, 16'h00ff);
      bus_write(RegTxData, 16'hff00);
      bus_write(RegControl, control_value(16'hf8f0, WidthByte, 1'b1, 1'b1, 1'b1));
      bus_read(RegStatus);
      bus_write(RegPeriod, 16'h1234);
      slave_reply(8'hff);
      slave_reply(8'h00);
      bus_read(RegRxData);
      bus_read(RegStatus);
      bus_write(RegControl, control_value(16'h0000, WidthWord, 1'b1, 1'b1, 1'b0));
      bus_write(RegTxData, 16'hffff);
      bus_write(RegControl, control_value(16'h0000, WidthWord, 1'b1, 1'b1, 1'b1));
      slave_reply(8'h5a);
      slave_reply(8'ha5);
      bus_write(RegControl, control_value(16'h0000, 4'd3, 1'b1, 1'b1, 1'b0));
      bus_write(RegTxData, 16'h0000);
      bus_write(RegControl, control_value(16'h0000, 4'd3, 1'b1, 1'b1, 1'b1));
      // exchange without master is dropped
      bus_write(RegControl, control_value(16'h0000, WidthByte, 1'b1, 1'b0, 1'b1));
      bus_read(RegControl);
      // empty TX: exchange ends at once
      bus_write(RegControl, control_value(16'h0000, WidthByte, 1'b1, 1'b1, 1'b1));
      bus_write(RegControl, 16'h0000);
      slave_reply(8'h3c);
      queue_word(OpUnused, RegUnusedHi, 16'hffff, 8'hff);
      bus_read(RegUnusedLo);
      bus_write(RegUnusedHi, 16'hffff);

      base = access_queue.size();
      while (access_queue.size() - base < RandomWords) begin
         if (!paused && access_queue.size() - base > 650) begin
            drain_next = 1'b1;
            paused = 1'b1;
         end else if ($urandom_range(49) == 0) begin
            drain_next = 1'b1;
         end
         if ($urandom_range(9) < 7) begin
            exchange_sequence();
         end else begin
            repeat ($urandom_range(1, 6))
               queue_word(2'($urandom_range(3)), 3'($urandom_range(7)), pick_data(),
                          pick_reply());
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (access_queue.size() != 0 || req_valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (FifoDepth + 20) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin : driver
      spi_access_t nxt;
      bit idle;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(spi_predict(offered));
            words_accepted++;
         end
         if (!req_valid || req_ready) begin
            idle = (words_accepted < 500 || words_accepted > 800) && $urandom_range(99) < 8;
            if (access_queue.size() == 0 || idle ||
                (access_queue[0].drain_first && expected_results.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               nxt = access_queue.pop_front();
               offered = nxt;
               req_valid <= 1'b1;
               req_operation <= nxt.op;
               req_reg_index <= nxt.idx;
               req_write_data <= nxt.wdata;
               req_reply_byte <= nxt.reply;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      spi_result_t want;
      bit ready_next;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch("word with nothing expected", 16'h0001, 16'h0000);
            end else begin
               want = expected_results.pop_front();
               if (rsp_read_data !== want.read_data)
                  report_mismatch("read_data", rsp_read_data, want.read_data);
               if (rsp_irq !== want.irq)
                  report_mismatch("irq", 16'(rsp_irq), 16'(want.irq));
               if (rsp_send_valid !== want.send_valid)
                  report_mismatch("send_valid", 16'(rsp_send_valid), 16'(want.send_valid));
               if (rsp_send_byte !== want.send_byte)
                  report_mismatch("send_byte", 16'(rsp_send_byte), 16'(want.send_byte));
               if (rsp_exchange_busy !== want.busy)
                  report_mismatch("exchange_busy", 16'(rsp_exchange_busy), 16'(want.busy));
               if (rsp_access_refused !== want.refused)
                  report_mismatch("access_refused", 16'(rsp_access_refused),
                                  16'(want.refused));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (!held_once && results_seen >= 300) begin
            held_once = 1'b1;
            hold_left = HoldOffCycles;
            ready_next = 1'b0;
         end else begin
            ready_next = (results_seen >= 500 && results_seen <= 800) ||
                         $urandom_range(99) >= 8;
         end
         rsp_ready <= ready_next;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("timeout: no word moved for %0d cycles", idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
